>>> hw/rtl/loop_rate_moving_average_core_defines.svh
`ifndef LOOP_RATE_MOVING_AVERAGE_CORE_DEFINES_SVH
`define LOOP_RATE_MOVING_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrma: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrma: next-cycle check failed");

`endif

>>> hw/rtl/lrma_pkg.sv
`timescale 1ns / 1ps

package lrma_pkg;

  localparam int STAMP_W        = 32;
  localparam int TPS_W          = 32;
  localparam int RATE_W         = 48;
  localparam int FRAC_W         = 16;
  localparam int WINDOW_DEFAULT = 100;
  localparam int ACC_W_DEFAULT  = RATE_W + $clog2(WINDOW_DEFAULT);

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000000);
  localparam logic [RATE_W-1:0] RATE_SAT  = {RATE_W{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RATE   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_MEAN   = 5'b01000,
    S_DONE   = 5'b10000
  } seq_state_t;

endpackage

>>> hw/rtl/lrma_stamp_if.sv
`timescale 1ns / 1ps

interface lrma_stamp_if;
  logic                         valid;
  logic                         ready;
  logic [lrma_pkg::STAMP_W-1:0] time_stamp;

  modport source (output valid, output time_stamp, input ready);
  modport sink   (input valid, input time_stamp, output ready);
endinterface

>>> hw/rtl/lrma_rate_if.sv
`timescale 1ns / 1ps

interface lrma_rate_if;
  logic                        valid;
  logic                        ready;
  logic [lrma_pkg::RATE_W-1:0] average_rate;
  logic                        rate_valid;
  logic                        zero_interval;

  modport source (output valid, output average_rate, output rate_valid,
                  output zero_interval, input ready);
  modport sink   (input valid, input average_rate, input rate_valid,
                  input zero_interval, output ready);
endinterface

>>> hw/rtl/lrma_ring.sv
`timescale 1ns / 1ps

module lrma_ring #(
  parameter int WINDOW = lrma_pkg::WINDOW_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(WINDOW)-1:0]   rd_addr,
  output logic [lrma_pkg::RATE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(WINDOW)-1:0]   wr_addr,
  input  logic [lrma_pkg::RATE_W-1:0] wr_data
);

  logic [lrma_pkg::RATE_W-1:0] mem [WINDOW];
  logic [lrma_pkg::RATE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/lrma_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lrma_div #(
  parameter int DVD_W = lrma_pkg::ACC_W_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [lrma_pkg::TPS_W-1:0]  divisor,
  output logic                        done,
  output logic [DVD_W-1:0]            quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int DS_W  = lrma_pkg::TPS_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DS_W-1:0]  rem_r, rem_nxt;
  logic [DS_W-1:0]  d_r, d_nxt;

  logic [DS_W:0] shifted;
  logic [DS_W:0] diff;
  logic          ge;

  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = shifted >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DS_W-1:0] : shifted[DS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> hw/rtl/loop_rate_moving_average_core.sv
`timescale 1ns / 1ps

// Moving-average loop-frequency meter. Each beat on in_stamp carries a
// free-running tick timestamp; each accepted beat yields exactly one beat on
// out_rate. The first timestamp after reset is only stored and answers with
// rate_valid = 0 and average_rate = 0. Every later timestamp forms the tick
// interval to the previous one (modulo 2^32), turns it into a 32.16 frequency
// floor(ticks_per_second * 2^16 / interval), pushes that into a ring of
// WINDOW entries and reports the truncated mean of the filled entries. A zero
// interval saturates the frequency to all ones and sets zero_interval; that
// value is averaged like any other. ticks_per_second resets to 1000000; the
// user must write it through cfg_we / cfg_wdata only while the block is idle,
// which the block itself does not enforce. Both divisions run on one shared
// restoring divider that retires one quotient bit per cycle over 48 +
// clog2(WINDOW) bits; the rate step is skipped on a zero interval, and the
// first timestamp skips both divisions. in_stamp.ready is high only while the
// sequencer is idle; a finished result waits in the output register, so the
// next timestamp can be taken while the previous result is still pending.
module loop_rate_moving_average_core #(
  parameter int WINDOW = lrma_pkg::WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lrma_stamp_if.sink                 in_stamp,
  lrma_rate_if.source                out_rate,
  input  logic                       cfg_we,
  input  logic [lrma_pkg::TPS_W-1:0] cfg_wdata
);

  localparam int SW     = $clog2(WINDOW);
  localparam int CW     = $clog2(WINDOW + 1);
  localparam int ACC_W  = lrma_pkg::RATE_W + $clog2(WINDOW);
  localparam int RATE_W = lrma_pkg::RATE_W;
  localparam int TPS_W  = lrma_pkg::TPS_W;

  // Sequencer and loop state.
  lrma_pkg::seq_state_t state_r, state_nxt;

  logic [TPS_W-1:0]           tps_r;
  logic [lrma_pkg::STAMP_W-1:0] prev_r;
  logic                       have_prev_r;
  logic [SW-1:0]              slot_r, slot_nxt;
  logic                       full_r, full_nxt;
  logic [ACC_W-1:0]           total_r, total_nxt;

  // Per-beat result flags.
  logic res_valid_r;
  logic zero_r;

  // Output register.
  logic              out_valid_r;
  logic [RATE_W-1:0] out_avg_r;
  logic              out_rv_r;
  logic              out_zero_r;

  logic                         in_fire;
  logic [lrma_pkg::STAMP_W-1:0] interval;
  logic                         interval_zero;
  logic                         out_load;
  logic                         wrap;
  logic [CW-1:0]                count;
  logic [RATE_W-1:0]            rate_w;
  logic [RATE_W-1:0]            old_rate;

  logic             div_start;
  logic [ACC_W-1:0] div_dividend;
  logic [TPS_W-1:0] div_divisor;
  logic             div_done;
  logic [ACC_W-1:0] div_q;

  assign in_stamp.ready = (state_r == lrma_pkg::S_IDLE);
  assign in_fire        = in_stamp.valid && in_stamp.ready;
  assign interval       = in_stamp.time_stamp - prev_r;
  assign interval_zero  = (interval == '0);

  // Frequency of this interval: divider result, or saturated on a zero gap.
  assign rate_w = zero_r ? lrma_pkg::RATE_SAT : div_q[RATE_W-1:0];

  // Advance the write slot and find the number of filled entries.
  assign wrap     = (slot_r == SW'(WINDOW - 1));
  assign slot_nxt = wrap ? '0 : slot_r + SW'(1);
  assign full_nxt = full_r | wrap;
  assign count    = full_nxt ? CW'(WINDOW) : CW'(slot_nxt);

  // Drop the overwritten entry once the ring has wrapped, add the new one.
  assign total_nxt = total_r - (full_r ? ACC_W'(old_rate) : '0) + ACC_W'(rate_w);

  // Divider is shared: frequency on accept, mean in the update step.
  assign div_start = (in_fire && have_prev_r && !interval_zero)
                   || (state_r == lrma_pkg::S_UPDATE);

  always_comb begin
    if (state_r == lrma_pkg::S_UPDATE) begin
      div_dividend = total_nxt;
      div_divisor  = TPS_W'(count);
    end else begin
      div_dividend = ACC_W'({tps_r, {lrma_pkg::FRAC_W{1'b0}}});
      div_divisor  = interval;
    end
  end

  lrma_div #(
    .DVD_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Fetch the entry at the write slot on accept; the registered word is held
  // until the update step uses it.
  lrma_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (slot_r),
    .rd_data (old_rate),
    .wr_en   (state_r == lrma_pkg::S_UPDATE),
    .wr_addr (slot_r),
    .wr_data (rate_w)
  );

  assign out_load = (state_r == lrma_pkg::S_DONE) && (!out_valid_r || out_rate.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrma_pkg::S_IDLE: begin
        if (in_fire) begin
          if (!have_prev_r) begin
            state_nxt = lrma_pkg::S_DONE;
          end else if (interval_zero) begin
            state_nxt = lrma_pkg::S_UPDATE;
          end else begin
            state_nxt = lrma_pkg::S_RATE;
          end
        end
      end
      lrma_pkg::S_RATE: begin
        if (div_done) begin
          state_nxt = lrma_pkg::S_UPDATE;
        end
      end
      lrma_pkg::S_UPDATE: begin
        state_nxt = lrma_pkg::S_MEAN;
      end
      lrma_pkg::S_MEAN: begin
        if (div_done) begin
          state_nxt = lrma_pkg::S_DONE;
        end
      end
      lrma_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = lrma_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lrma_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrma_pkg::S_IDLE;
      tps_r       <= lrma_pkg::TPS_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (in_fire) begin
        prev_r      <= in_stamp.time_stamp;
        have_prev_r <= 1'b1;
      end
      if (state_r == lrma_pkg::S_UPDATE) begin
        slot_r  <= slot_nxt;
        full_r  <= full_nxt;
        total_r <= total_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rate.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result flags and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_valid_r <= have_prev_r;
      zero_r      <= have_prev_r && interval_zero;
    end
    if (out_load) begin
      out_avg_r  <= res_valid_r ? div_q[RATE_W-1:0] : '0;
      out_rv_r   <= res_valid_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_rate.valid         = out_valid_r;
  assign out_rate.average_rate  = out_avg_r;
  assign out_rate.rate_valid    = out_rv_r;
  assign out_rate.zero_interval = out_zero_r;

endmodule

>>> hw/rtl/lrma_checker.sv
`timescale 1ns / 1ps

`include "loop_rate_moving_average_core_defines.svh"

module lrma_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrma_pkg::RATE_W-1:0] out_avg,
  input logic                        out_rate_valid,
  input logic                        out_zero
);

  // One timestamp at a time: busy right after a beat is taken.
  `LRMA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // The first-timestamp answer carries no rate and no zero flag.
  `LRMA_ASSERT_NOW(a_first_is_zero, out_valid && !out_rate_valid,
                   out_avg == '0 && !out_zero)

  // A stalled result beat holds its value.
  `LRMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_avg))

  // A zero gap always averages in the saturated rate, so the mean is nonzero.
  `LRMA_ASSERT_NOW(a_zero_mean_nonzero, out_valid && out_zero,
                   out_rate_valid && out_avg != '0)

endmodule

bind loop_rate_moving_average_core lrma_checker u_lrma_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_stamp.valid),
  .in_ready       (in_stamp.ready),
  .out_valid      (out_rate.valid),
  .out_ready      (out_rate.ready),
  .out_avg        (out_rate.average_rate),
  .out_rate_valid (out_rate.rate_valid),
  .out_zero       (out_rate.zero_interval)
);
